>>> sv/aqpf_pkg.sv
// aqpf_pkg: shared types and constants for the ack quorum packet filter
// used by aqpf_regs, aqpf_ctrl, aqpf_dp and ack_quorum_packet_filter_unit
// no dependencies
package aqpf_pkg;

	// header match values
	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [7:0] IP_UDP = 8'd17;
	localparam logic [3:0] IHL_NO_OPT = 4'd5;
	localparam logic [10:0] MIN_PAYLOAD = 11'd35;

	// message fields
	localparam logic [7:0] RESP_KIND = 8'h21;
	localparam int FLAG_OK_BIT = 0;
	localparam logic [15:0] FLAG_QUORUM = 16'h0002;
	localparam logic [15:0] MAX_NODE = 16'd31;
	localparam int NODE_W = 5;
	localparam int MEMBER_W = 31;
	localparam int COUNT_W = 5;

	// register defaults and layout
	localparam logic [15:0] SERVICE_PORT_RST = 16'd9000;
	localparam logic [4:0] THRESHOLD_RST = 5'd2;
	localparam int ADDR_W = 3;
	localparam int REG_SEL_BIT = 2;
	localparam logic REG_SERVICE_PORT = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	// slot table default depth
	localparam int SLOT_COUNT_DEF = 4096;

	// statistics classes
	typedef enum logic [1:0] {
		STAT_DROP  = 2'd0,
		STAT_MARK  = 2'd1,
		STAT_OTHER = 2'd2,
		STAT_NONE  = 2'd3
	} stat_class_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;
		logic capture;
		logic div1;
		logic div2;
		logic rd;
		logic finish;
	} aqpf_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_slot;
		logic clr_last;
	} aqpf_stat_t;

endpackage

>>> sv/aqpf_regs.sv
// aqpf_regs: apb configuration registers (service port, quorum threshold)
// depends on aqpf_pkg
module aqpf_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aqpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [15:0]                 service_port,
	output logic [4:0]                  quorum_threshold
);

	logic        wr_en;
	logic        sel;
	logic [15:0] port_q;
	logic [4:0]  thr_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = paddr[aqpf_pkg::REG_SEL_BIT];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= aqpf_pkg::SERVICE_PORT_RST;
			thr_q  <= aqpf_pkg::THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (sel)
				aqpf_pkg::REG_SERVICE_PORT: port_q <= pwdata[15:0];
				aqpf_pkg::REG_THRESHOLD:    thr_q  <= pwdata[4:0];
				default:                    port_q <= port_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (sel)
			aqpf_pkg::REG_SERVICE_PORT: prdata = {16'd0, port_q};
			aqpf_pkg::REG_THRESHOLD:    prdata = {27'd0, thr_q};
			default:                    prdata = 32'd0;
		endcase
	end

	assign service_port     = port_q;
	assign quorum_threshold = thr_q;

endmodule

>>> sv/aqpf_ctrl.sv
// aqpf_ctrl: controller state machine, sequences clear pass, slot index,
// slot read and update; owns the input ready and result valid
// depends on aqpf_pkg
module aqpf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  aqpf_pkg::aqpf_stat_t  stat,
	output aqpf_pkg::aqpf_cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DIV1  = 6'b000100,
		S_DIV2  = 6'b001000,
		S_RD    = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign slot_free = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = stat.in_slot ? S_DIV1 : S_FIN;
				end
			end
			S_DIV1: begin
				cmd.div1 = 1'b1;
				state_d  = S_DIV2;
			end
			S_DIV2: begin
				cmd.div2 = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/aqpf_dp.sv
// aqpf_dp: datapath with header classification, slot index remainder unit,
// slot memory, statistics counters and result register
// depends on aqpf_pkg
module aqpf_dp #(
	parameter int SLOT_COUNT = aqpf_pkg::SLOT_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aqpf_pkg::aqpf_cmd_t  cmd,
	output aqpf_pkg::aqpf_stat_t stat,
	input  logic [15:0]          service_port,
	input  logic [4:0]           quorum_threshold,
	input  logic                 headers_complete,
	input  logic [15:0]          ethertype,
	input  logic [7:0]           ip_protocol,
	input  logic [3:0]           ip_header_words,
	input  logic [15:0]          udp_dest_port,
	input  logic [10:0]          payload_len,
	input  logic [7:0]           msg_type,
	input  logic [15:0]          resp_flags,
	input  logic [31:0]          seq,
	input  logic [15:0]          node_id,
	output logic                 pass,
	output logic                 quorum_mark,
	output logic [15:0]          flags_out,
	output logic [1:0]           stat_class,
	output logic [63:0]          stat_value
);

	localparam int IDX_W    = $clog2(SLOT_COUNT);
	localparam int NW       = $clog2(SLOT_COUNT + 1);
	localparam int SH       = 32 + IDX_W;
	localparam int RECIP_W  = 34;
	localparam int PROD_W   = SH + 34;
	localparam int MEMBER_W = aqpf_pkg::MEMBER_W;
	localparam int COUNT_W  = aqpf_pkg::COUNT_W;
	localparam int NODE_W   = aqpf_pkg::NODE_W;
	localparam int MEM_W    = 32 + MEMBER_W + COUNT_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SH) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam logic [NW-1:0] N_C = NW'(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	// captured item
	logic [31:0]        seq_q;
	logic [NODE_W-1:0]  node_q;
	logic [15:0]        flags_q;
	logic               slot_q;
	logic               other_q;

	// index unit
	logic [PROD_W-1:0]  prod;
	logic [31:0]        quot_q;
	logic [31+NW:0]     qn_full;
	logic [31:0]        rem;
	logic [IDX_W-1:0]   idx_q;

	// slot memory
	logic [MEM_W-1:0]   slot_mem [SLOT_COUNT];
	logic [MEM_W-1:0]   rd_q;
	logic [IDX_W-1:0]   clr_q;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [MEM_W-1:0]   wr_data;

	// update
	logic                pkt_ok;
	logic                ack_ok;
	logic [31:0]         rd_tag;
	logic [MEMBER_W-1:0] rd_members;
	logic [COUNT_W-1:0]  rd_count;
	logic                hit;
	logic [MEMBER_W-1:0] mem_base;
	logic [COUNT_W-1:0]  cnt_base;
	logic [MEMBER_W-1:0] node_bit;
	logic                fresh;
	logic [MEMBER_W-1:0] mem_new;
	logic [COUNT_W-1:0]  cnt_new;
	logic                reached;

	// statistics and result
	logic [63:0]           cnt_q [3];
	logic [63:0]           sel_cnt;
	logic [63:0]           cnt_inc;
	aqpf_pkg::stat_class_t cls;
	logic                  pass_q;
	logic                  mark_q;
	logic [15:0]           flags_out_q;
	aqpf_pkg::stat_class_t class_q;
	logic [63:0]           value_q;

	// header and message classification on the incoming item
	assign pkt_ok = headers_complete
		&& (ethertype == aqpf_pkg::ETH_IPV4)
		&& (ip_protocol == aqpf_pkg::IP_UDP)
		&& (ip_header_words == aqpf_pkg::IHL_NO_OPT)
		&& (udp_dest_port == service_port)
		&& (payload_len >= aqpf_pkg::MIN_PAYLOAD);
	assign ack_ok = (msg_type == aqpf_pkg::RESP_KIND)
		&& resp_flags[aqpf_pkg::FLAG_OK_BIT]
		&& (seq != 32'd0)
		&& (node_id != 16'd0)
		&& (node_id <= aqpf_pkg::MAX_NODE);

	assign stat.in_slot  = pkt_ok & ack_ok;
	assign stat.clr_last = (clr_q == LAST_IDX);

	// capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= 1'b0;
			other_q <= 1'b0;
		end else if (cmd.capture) begin
			slot_q  <= pkt_ok & ack_ok;
			other_q <= pkt_ok & ~ack_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_q   <= seq;
			node_q  <= node_id[NODE_W-1:0];
			flags_q <= resp_flags;
		end
	end

	// slot index: quotient by reciprocal multiply, then remainder
	assign prod    = seq_q * RECIP;
	assign qn_full = quot_q * N_C;
	assign rem     = seq_q - qn_full[31:0];

	always_ff @(posedge clk) begin
		if (cmd.div1) begin
			quot_q <= prod[SH +: 32];
		end
		if (cmd.div2) begin
			idx_q <= rem[IDX_W-1:0];
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	// slot entry update
	assign rd_tag     = rd_q[MEM_W-1 -: 32];
	assign rd_members = rd_q[COUNT_W +: MEMBER_W];
	assign rd_count   = rd_q[COUNT_W-1:0];
	assign hit        = (rd_tag == seq_q);
	assign mem_base   = hit ? rd_members : '0;
	assign cnt_base   = hit ? rd_count : '0;
	assign node_bit   = MEMBER_W'(1) << (node_q - NODE_W'(1));
	assign fresh      = ((mem_base & node_bit) == '0);
	assign mem_new    = mem_base | node_bit;
	assign cnt_new    = cnt_base + COUNT_W'(fresh);
	assign reached    = (cnt_new >= quorum_threshold);

	// memory write port
	assign wr_en   = cmd.clear | (cmd.finish & slot_q);
	assign wr_addr = cmd.clear ? clr_q : idx_q;
	assign wr_data = cmd.clear ? '0 : {seq_q, mem_new, cnt_new};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
	end

	// memory read port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= slot_mem[idx_q];
		end
	end

	// item class
	always_comb begin
		priority if (slot_q) begin
			cls = reached ? aqpf_pkg::STAT_MARK : aqpf_pkg::STAT_DROP;
		end else if (other_q) begin
			cls = aqpf_pkg::STAT_OTHER;
		end else begin
			cls = aqpf_pkg::STAT_NONE;
		end
	end

	// counter select
	always_comb begin
		unique case (cls)
			aqpf_pkg::STAT_DROP:  sel_cnt = cnt_q[0];
			aqpf_pkg::STAT_MARK:  sel_cnt = cnt_q[1];
			aqpf_pkg::STAT_OTHER: sel_cnt = cnt_q[2];
			default:              sel_cnt = 64'd0;
		endcase
	end

	assign cnt_inc = sel_cnt + 64'd1;

	// statistics counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= 64'd0;
			cnt_q[1] <= 64'd0;
			cnt_q[2] <= 64'd0;
		end else if (cmd.finish) begin
			unique case (cls)
				aqpf_pkg::STAT_DROP:  cnt_q[0] <= cnt_inc;
				aqpf_pkg::STAT_MARK:  cnt_q[1] <= cnt_inc;
				aqpf_pkg::STAT_OTHER: cnt_q[2] <= cnt_inc;
				default:              cnt_q[0] <= cnt_q[0];
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pass_q      <= (cls != aqpf_pkg::STAT_DROP);
			mark_q      <= (cls == aqpf_pkg::STAT_MARK);
			flags_out_q <= (cls == aqpf_pkg::STAT_MARK) ?
				(flags_q | aqpf_pkg::FLAG_QUORUM) : flags_q;
			class_q     <= cls;
			value_q     <= (cls == aqpf_pkg::STAT_NONE) ? 64'd0 : cnt_inc;
		end
	end

	assign pass        = pass_q;
	assign quorum_mark = mark_q;
	assign flags_out   = flags_out_q;
	assign stat_class  = class_q;
	assign stat_value  = value_q;

endmodule

>>> sv/ack_quorum_packet_filter_unit.sv
// ack_quorum_packet_filter_unit: top level of the ack quorum packet filter
// depends on aqpf_pkg, aqpf_regs, aqpf_ctrl, aqpf_dp
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------------
//   in      | in_valid / in_ready    | headers_complete .. node_id (one packet)
//   out     | out_valid / out_ready  | pass, quorum_mark, flags_out, stat_class,
//           |                        | stat_value
//   config  | psel, penable, pwrite, | service_port at 0x0, quorum_threshold at 0x4
//           | pready (always high)   |
//
// uncounted and "other" items go through capture and the result step only;
// acknowledgements that use a slot go through capture, quotient multiply, remainder,
// slot memory read and update/write. the two-step slot index and the slot memory
// read-modify-write make this the longer path. after reset a clearing pass zeroes
// every slot memory entry, with in_ready low. a new item is taken while a result
// waits; the update step holds until the result register is free.
module ack_quorum_packet_filter_unit #(
	parameter int SLOT_COUNT = aqpf_pkg::SLOT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aqpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        headers_complete,
	input  logic [15:0]                 ethertype,
	input  logic [7:0]                  ip_protocol,
	input  logic [3:0]                  ip_header_words,
	input  logic [15:0]                 udp_dest_port,
	input  logic [10:0]                 payload_len,
	input  logic [7:0]                  msg_type,
	input  logic [15:0]                 resp_flags,
	input  logic [31:0]                 seq,
	input  logic [15:0]                 node_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        pass,
	output logic                        quorum_mark,
	output logic [15:0]                 flags_out,
	output logic [1:0]                  stat_class,
	output logic [63:0]                 stat_value
);

	logic [15:0]          service_port;
	logic [4:0]           quorum_threshold;
	aqpf_pkg::aqpf_cmd_t  cmd;
	aqpf_pkg::aqpf_stat_t stat;

	// configuration registers
	aqpf_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.service_port     (service_port),
		.quorum_threshold (quorum_threshold)
	);

	// sequencing
	aqpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// slot table, counters and result
	aqpf_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.service_port     (service_port),
		.quorum_threshold (quorum_threshold),
		.headers_complete (headers_complete),
		.ethertype        (ethertype),
		.ip_protocol      (ip_protocol),
		.ip_header_words  (ip_header_words),
		.udp_dest_port    (udp_dest_port),
		.payload_len      (payload_len),
		.msg_type         (msg_type),
		.resp_flags       (resp_flags),
		.seq              (seq),
		.node_id          (node_id),
		.pass             (pass),
		.quorum_mark      (quorum_mark),
		.flags_out        (flags_out),
		.stat_class       (stat_class),
		.stat_value       (stat_value)
	);

endmodule
